// ===== hw/rtl/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// shared types and constants for the capture period meter
// ----------------------------------------------------------------------------
package cpm_pkg;

    // width of the free-running hardware counter
    localparam int CounterBits = 16;

    localparam int ValueBits   = 16;
    localparam int PeriodBits  = 32;
    localparam int UpperBits   = 16;

    localparam int InDataBits  = 24;
    localparam int OutDataBits = 40;

    // low counter bits kept from the captured value
    localparam logic [ValueBits-1:0] ValueMask = (CounterBits >= ValueBits) ?
        {ValueBits{1'b1}} : ValueBits'((1 << CounterBits) - 1);

    // midpoint of the counter range
    localparam logic [PeriodBits:0] HalfSpan = (PeriodBits + 1)'(1) << (CounterBits - 1);

    typedef struct packed {
        logic                 read_renew;
        logic                 after_point_event;
        logic                 before_point_event;
        logic [ValueBits-1:0] capture_value;
        logic                 capture_event;
        logic                 overflow_event;
    } t_in_item;

    typedef struct packed {
        logic                  renew_seen;
        logic [PeriodBits-1:0] period;
    } t_out_item;

    typedef struct packed {
        logic [UpperBits-1:0]  upper_count;
        logic [PeriodBits-1:0] previous_capture;
        logic [PeriodBits-1:0] latest_period;
        logic                  in_window;
        logic                  overflow_applied;
        logic                  primed;
        logic                  renew_flag;
    } t_state;

endpackage

// ===== hw/rtl/capture_period_meter.sv =====
// ----------------------------------------------------------------------------
// capture_period_meter
// 32-bit period measurement between input-capture events of a timer
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       event item, 24-bit tdata
// m_axis    out  m_axis_tvalid/tready       period result, 40-bit tdata
//
// one result per item; each item passes from the input register through the state update into the result register
// an item can be taken every cycle while m_axis is not stalled; the state update is combinational
// input register and result register decouple the two sides
// input stalls only while both registers hold items and m_axis is stalled
// synchronous active-low reset clears the meter state and valid flags, no period measured yet
// ----------------------------------------------------------------------------
module capture_period_meter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // overflow_event, capture_event, capture_value[15:0], before_point_event,
    // after_point_event, read_renew, zero pad
    input  logic [cpm_pkg::InDataBits-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // period[31:0], renew_seen, zero pad
    output logic [cpm_pkg::OutDataBits-1:0] m_axis_tdata
);

    logic               r_in_valid;
    cpm_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    cpm_pkg::t_out_item r_out_item;
    cpm_pkg::t_state    r_state;
    cpm_pkg::t_state    n_state;
    cpm_pkg::t_out_item n_result;
    logic               advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= s_axis_tdata[$bits(cpm_pkg::t_in_item)-1:0];
        end
    end

    cpm_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(cpm_pkg::OutDataBits - $bits(cpm_pkg::t_out_item))'(0),
                            r_out_item};

endmodule

// ===== hw/rtl/cpm_step.sv =====
// ----------------------------------------------------------------------------
// cpm_step
// next-state and result logic for one event item
// ----------------------------------------------------------------------------
module cpm_step (
    input  cpm_pkg::t_state    i_state,
    input  cpm_pkg::t_in_item  i_item,
    output cpm_pkg::t_state    o_state,
    output cpm_pkg::t_out_item o_result
);

    logic [cpm_pkg::ValueBits-1:0]  val;
    logic                           ovf_count;
    logic                           late_count;
    logic [cpm_pkg::UpperBits-1:0]  upper_a;
    logic [cpm_pkg::UpperBits-1:0]  upper_b;
    logic [cpm_pkg::PeriodBits-1:0] now_ext;
    logic                           applied_a;
    cpm_pkg::t_state                s;

    assign val = i_item.capture_value & cpm_pkg::ValueMask;

    always_comb begin
        // overflow flag counts once per window
        ovf_count = i_item.overflow_event && !i_state.overflow_applied;
        applied_a = i_state.overflow_applied || ovf_count;
        upper_a   = i_state.upper_count + cpm_pkg::UpperBits'(ovf_count);

        // capture in the lower half after the before-point owns a pending overflow
        late_count = i_item.capture_event && i_state.in_window && !applied_a &&
                     ({(cpm_pkg::PeriodBits + 1 - cpm_pkg::ValueBits)'(0), val} <
                      cpm_pkg::HalfSpan);
        upper_b = upper_a + cpm_pkg::UpperBits'(late_count);

        now_ext = (cpm_pkg::PeriodBits'(upper_b) << cpm_pkg::CounterBits) +
                  cpm_pkg::PeriodBits'(val);

        s                  = i_state;
        s.upper_count      = upper_b;
        s.overflow_applied = applied_a || late_count;
        if (i_item.capture_event) begin
            if (i_state.primed) begin
                s.latest_period = now_ext - i_state.previous_capture;
                s.renew_flag    = 1'b1;
            end else begin
                s.primed = 1'b1;
            end
            s.previous_capture = now_ext;
        end
        if (i_item.before_point_event) begin
            s.in_window = 1'b1;
        end
        if (i_item.after_point_event) begin
            s.in_window        = 1'b0;
            s.overflow_applied = 1'b0;
        end

        o_result.period     = s.latest_period;
        o_result.renew_seen = s.renew_flag;
        if (i_item.read_renew) begin
            s.renew_flag = 1'b0;
        end
        o_state = s;
    end

endmodule

// ===== hw/rtl/cpm_checker.sv =====
// ----------------------------------------------------------------------------
// cpm_checker
// port-level checks for the capture period meter
// ----------------------------------------------------------------------------
module cpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cpm_pkg::OutDataBits-1:0] m_axis_tdata
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while result side can move");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items in flight");

    a_no_result_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 2'd0)
        else $error("result without an item in flight");

endmodule

bind capture_period_meter cpm_checker u_cpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
